/* sv/serial_port_registers_baud_timer_defines.svh */
`ifndef SERIAL_PORT_REGISTERS_BAUD_TIMER_DEFINES_SVH
`define SERIAL_PORT_REGISTERS_BAUD_TIMER_DEFINES_SVH

// concurrent check, off while reset is high
`define SPRBT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also covers the reset cycles
`define SPRBT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sprbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sprbt_pkg;

   localparam int CdWidth      = 22;
   localparam int TimerShift   = 11;
   localparam int TimerBits    = 32 - TimerShift;
   localparam int CycWidth     = 16;
   localparam int ReqDataWidth = 56;
   localparam int RspDataWidth = 48;

   localparam logic [15:0]        BaudReset = 16'h00DC;
   localparam logic [CdWidth-1:0] CdReset   = 22'd220;

   // request kinds
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // access sizes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   // halfword register index (offset bits 3:1)
   localparam logic [2:0] HW_DATA0   = 3'd0;
   localparam logic [2:0] HW_DATA1   = 3'd1;
   localparam logic [2:0] HW_STAT_LO = 3'd2;
   localparam logic [2:0] HW_STAT_HI = 3'd3;
   localparam logic [2:0] HW_MODE    = 3'd4;
   localparam logic [2:0] HW_CTL     = 3'd5;
   localparam logic [2:0] HW_UNUSED  = 3'd6;
   localparam logic [2:0] HW_BAUD    = 3'd7;

   // word register index (offset bits 3:2)
   localparam logic [1:0] WD_DATA    = 2'd0;
   localparam logic [1:0] WD_STAT    = 2'd1;
   localparam logic [1:0] WD_MODECTL = 2'd2;
   localparam logic [1:0] WD_BAUD    = 2'd3;

   // control and status bit positions
   localparam int CtlTxEn   = 0;
   localparam int CtlAck    = 4;
   localparam int CtlReset  = 6;
   localparam int CtlTxIrq  = 10;
   localparam int StIdleBit = 2;
   localparam int StIrqBit  = 9;

   typedef struct packed {
      logic                start;
      logic [CycWidth-1:0] dividend;
      logic [CdWidth-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [CdWidth-1:0] remainder;
   } div_rsp_type;

   // baud times 1, 1, 16 or 64; a zero product reloads as 1
   function automatic logic [CdWidth-1:0] reload_value(input logic [15:0] baud,
                                                       input logic [1:0]  mode);
      logic [CdWidth-1:0] r;
      case (mode)
         2'd2:    r = {2'b00, baud, 4'b0000};
         2'd3:    r = {baud, 6'b000000};
         default: r = {6'b000000, baud};
      endcase
      if (r == '0) begin
         r = 22'd1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/sprbt_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module sprbt_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sprbt_pkg::div_req_type req,
   output sprbt_pkg::div_rsp_type     rsp
);

   logic [sprbt_pkg::CdWidth-1:0]  rem_ff, rem_in;
   logic [sprbt_pkg::CdWidth-1:0]  dsr_ff, dsr_in;
   logic [sprbt_pkg::CycWidth-1:0] dvd_ff, dvd_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [sprbt_pkg::CdWidth:0]    trial;
   logic [sprbt_pkg::CdWidth:0]    diff;

   // one restoring step: bring down the next dividend bit
   assign trial = {rem_ff, dvd_ff[sprbt_pkg::CycWidth-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dsr_in  = req.divisor;
         dvd_in  = req.dividend;
         cnt_in  = 4'(sprbt_pkg::CycWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[sprbt_pkg::CdWidth-1:0];
         end else begin
            rem_in = trial[sprbt_pkg::CdWidth-1:0];
         end
         dvd_in = {dvd_ff[sprbt_pkg::CycWidth-2:0], 1'b0};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule
`default_nettype wire

/* sv/serial_port_registers_baud_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Serial port register window (16 bytes) with a down-counting baud timer. A request is
// a read, a write or a tick of elapsed cycles; each request gives exactly one response.
// The block takes one request at a time: a register read or write or a tick shorter
// than the remaining count is executed in ST_EXEC and its response is registered onto
// rsp_tvalid; a tick that reaches zero runs the remainder by the reload value through
// a one-bit-per-cycle divider (16 steps) in ST_DIV and gives its response from ST_DONE.
// req_tready rises in the same cycle as rsp_tvalid; a response still waiting on
// rsp_tready holds the next request until it is taken. Status shows the low 21 timer
// bits from bit 11 up. csr_wr_en/csr_wr_data set console echo, which lets
// data-register writes show up as tx_valid/tx_byte in the response.
module serial_port_registers_baud_timer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic                                  csr_wr_data,  // console_echo
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // access_size[1:0], offset[5:2], write_data[37:6], tick_cycles[53:38]
   input  wire logic [sprbt_pkg::ReqDataWidth-1:0]    req_tdata,
   input  wire logic [1:0]                            req_tuser,    // request kind
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // read_data[31:0], irq_raise[32], tx_valid[33], tx_byte[41:34]
   output logic [sprbt_pkg::RspDataWidth-1:0]         rsp_tdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_DONE} state_type;

   state_type state_ff, state_in;

   logic                              echo_ff, echo_in;
   logic [15:0]                       mode_ff, mode_in;
   logic [15:0]                       ctl_ff, ctl_in;
   logic [15:0]                       baud_ff, baud_in;
   logic                              ready_ff, ready_in;
   logic                              idle_ff, idle_in;
   logic                              irq_ff, irq_in;
   logic [sprbt_pkg::CdWidth-1:0]     cd_ff, cd_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sprbt_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]                        op_ff, op_in;
   logic [1:0]                        size_ff, size_in;
   logic [3:0]                        off_ff, off_in;
   logic [31:0]                       wdata_ff, wdata_in;
   logic [sprbt_pkg::CycWidth-1:0]    cyc_ff, cyc_in;

   // results of executing the held request against the current registers
   logic [15:0]                       ex_mode, ex_ctl, ex_baud;
   logic                              ex_ready, ex_idle, ex_irq;
   logic [sprbt_pkg::CdWidth-1:0]     ex_cd;
   logic [31:0]                       ex_rd;
   logic                              ex_irq_raise, ex_txv;
   logic [7:0]                        ex_txb;

   logic [31:0]                       status_w;
   logic [sprbt_pkg::CdWidth-1:0]     reload_cur;
   logic                              long_tick;
   logic                              slot_free;

   sprbt_pkg::div_req_type            div_req;
   sprbt_pkg::div_rsp_type            div_rsp;

   sprbt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign status_w = (32'(cd_ff[sprbt_pkg::TimerBits-1:0]) << sprbt_pkg::TimerShift)
                   | (32'(irq_ff) << sprbt_pkg::StIrqBit)
                   | (32'(idle_ff) << sprbt_pkg::StIdleBit)
                   | 32'(ready_ff);

   assign reload_cur = sprbt_pkg::reload_value(baud_ff, mode_ff[1:0]);
   assign long_tick  = (op_ff == sprbt_pkg::OP_TICK)
                     && ({6'b000000, cyc_ff} >= cd_ff);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      logic [15:0] hw_rd;
      logic [31:0] wd_rd;
      logic [15:0] merged;
      logic [15:0] hval;
      logic        do_send, do_mode, do_ctl, do_baud;
      logic [7:0]  send_b;
      logic [15:0] mode_v, ctl_v, baud_v, ctl_m;

      unique case (off_ff[3:1]) inside
         sprbt_pkg::HW_DATA0, sprbt_pkg::HW_DATA1: hw_rd = 16'hFFFF;
         sprbt_pkg::HW_STAT_LO: hw_rd = status_w[15:0];
         sprbt_pkg::HW_STAT_HI: hw_rd = status_w[31:16];
         sprbt_pkg::HW_MODE:    hw_rd = mode_ff;
         sprbt_pkg::HW_CTL:     hw_rd = ctl_ff;
         sprbt_pkg::HW_BAUD:    hw_rd = baud_ff;
         default:               hw_rd = 16'h0000;
      endcase

      unique case (off_ff[3:2])
         sprbt_pkg::WD_DATA:    wd_rd = 32'hFFFF_FFFF;
         sprbt_pkg::WD_STAT:    wd_rd = status_w;
         sprbt_pkg::WD_MODECTL: wd_rd = {ctl_ff, mode_ff};
         default:               wd_rd = {baud_ff, 16'h0000};
      endcase

      // a byte write outside the low data halfword goes in as a read-merge-write of its halfword
      merged = off_ff[0] ? {wdata_ff[7:0], hw_rd[7:0]} : {hw_rd[15:8], wdata_ff[7:0]};
      if (size_ff == sprbt_pkg::SZ_HALF) begin
         hval = wdata_ff[15:0];
      end else if (off_ff[3:1] == sprbt_pkg::HW_DATA0) begin
         hval = {8'h00, wdata_ff[7:0]};
      end else begin
         hval = merged;
      end

      do_send = 1'b0;
      do_mode = 1'b0;
      do_ctl  = 1'b0;
      do_baud = 1'b0;
      send_b  = 8'h00;
      mode_v  = 16'h0000;
      ctl_v   = 16'h0000;
      baud_v  = 16'h0000;
      if (op_ff == sprbt_pkg::OP_WRITE) begin
         if (size_ff == sprbt_pkg::SZ_BYTE || size_ff == sprbt_pkg::SZ_HALF) begin
            case (off_ff[3:1]) inside
               sprbt_pkg::HW_DATA0, sprbt_pkg::HW_DATA1: begin
                  do_send = 1'b1;
                  send_b  = hval[7:0];
               end
               sprbt_pkg::HW_MODE: begin
                  do_mode = 1'b1;
                  mode_v  = hval;
               end
               sprbt_pkg::HW_CTL: begin
                  do_ctl = 1'b1;
                  ctl_v  = hval;
               end
               sprbt_pkg::HW_BAUD: begin
                  do_baud = 1'b1;
                  baud_v  = hval;
               end
               default: ;
            endcase
         end else if (size_ff == sprbt_pkg::SZ_WORD) begin
            case (off_ff[3:2])
               sprbt_pkg::WD_DATA: begin
                  do_send = 1'b1;
                  send_b  = wdata_ff[7:0];
               end
               sprbt_pkg::WD_MODECTL: begin
                  do_mode = 1'b1;
                  mode_v  = wdata_ff[15:0];
                  do_ctl  = 1'b1;
                  ctl_v   = wdata_ff[31:16];
               end
               sprbt_pkg::WD_BAUD: begin
                  do_baud = 1'b1;
                  baud_v  = wdata_ff[31:16];
               end
               default: ;
            endcase
         end
      end

      ex_mode      = mode_ff;
      ex_ctl       = ctl_ff;
      ex_baud      = baud_ff;
      ex_ready     = ready_ff;
      ex_idle      = idle_ff;
      ex_irq       = irq_ff;
      ex_cd        = cd_ff;
      ex_irq_raise = 1'b0;
      ex_txv       = 1'b0;
      ex_txb       = 8'h00;
      ex_rd        = 32'h0000_0000;

      if (op_ff == sprbt_pkg::OP_READ) begin
         case (size_ff)
            sprbt_pkg::SZ_BYTE: ex_rd = {24'h000000, off_ff[0] ? hw_rd[15:8] : hw_rd[7:0]};
            sprbt_pkg::SZ_HALF: ex_rd = {16'h0000, hw_rd};
            sprbt_pkg::SZ_WORD: ex_rd = wd_rd;
            default:            ex_rd = 32'h0000_0000;
         endcase
      end

      if (op_ff == sprbt_pkg::OP_TICK && !long_tick) begin
         ex_cd = cd_ff - {6'b000000, cyc_ff};
      end

      if (do_mode) begin
         ex_mode = mode_v;
      end

      if (do_send && ctl_ff[sprbt_pkg::CtlTxEn]) begin
         if (echo_ff) begin
            ex_txv = 1'b1;
            ex_txb = send_b;
         end
         ex_ready = 1'b1;
         ex_idle  = 1'b1;
         if (ctl_ff[sprbt_pkg::CtlTxIrq] && !irq_ff) begin
            ex_irq       = 1'b1;
            ex_irq_raise = 1'b1;
         end
      end

      ctl_m = ctl_v;
      ctl_m[sprbt_pkg::CtlAck]   = 1'b0;
      ctl_m[sprbt_pkg::CtlReset] = 1'b0;
      if (do_ctl) begin
         if (ctl_v[sprbt_pkg::CtlReset]) begin
            // soft reset drops the rest of the control value
            ex_mode  = 16'h0000;
            ex_ctl   = 16'h0000;
            ex_baud  = sprbt_pkg::BaudReset;
            ex_ready = 1'b1;
            ex_idle  = 1'b1;
            ex_irq   = 1'b0;
            ex_cd    = sprbt_pkg::CdReset;
         end else begin
            if (ctl_v[sprbt_pkg::CtlAck]) begin
               ex_irq = 1'b0;
            end
            ex_ctl = ctl_m;
            if (ctl_m[sprbt_pkg::CtlTxIrq] && ctl_m[sprbt_pkg::CtlTxEn] && idle_ff
                && !ex_irq) begin
               ex_irq       = 1'b1;
               ex_irq_raise = 1'b1;
            end
         end
      end

      if (do_baud) begin
         ex_baud = baud_v;
         ex_cd   = sprbt_pkg::reload_value(baud_v, ex_mode[1:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      echo_in      = csr_wr_en ? csr_wr_data : echo_ff;
      mode_in      = mode_ff;
      ctl_in       = ctl_ff;
      baud_in      = baud_ff;
      ready_in     = ready_ff;
      idle_in      = idle_ff;
      irq_in       = irq_ff;
      cd_in        = cd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      wdata_in     = wdata_ff;
      cyc_in       = cyc_ff;

      div_req.start    = 1'b0;
      div_req.dividend = cyc_ff - cd_ff[sprbt_pkg::CycWidth-1:0];
      div_req.divisor  = reload_cur;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               size_in  = req_tdata[1:0];
               off_in   = req_tdata[5:2];
               wdata_in = req_tdata[37:6];
               cyc_in   = req_tdata[53:38];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (long_tick) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else if (slot_free) begin
               mode_in      = ex_mode;
               ctl_in       = ex_ctl;
               baud_in      = ex_baud;
               ready_in     = ex_ready;
               idle_in      = ex_idle;
               irq_in       = ex_irq;
               cd_in        = ex_cd;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, ex_txb, ex_txv, ex_irq_raise, ex_rd};
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               // timer wraps: reload minus what is left over past the last reload
               cd_in        = reload_cur - div_rsp.remainder;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         echo_ff      <= 1'b0;
         mode_ff      <= 16'h0000;
         ctl_ff       <= 16'h0000;
         baud_ff      <= sprbt_pkg::BaudReset;
         ready_ff     <= 1'b1;
         idle_ff      <= 1'b1;
         irq_ff       <= 1'b0;
         cd_ff        <= sprbt_pkg::CdReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         echo_ff      <= echo_in;
         mode_ff      <= mode_in;
         ctl_ff       <= ctl_in;
         baud_ff      <= baud_in;
         ready_ff     <= ready_in;
         idle_ff      <= idle_in;
         irq_ff       <= irq_in;
         cd_ff        <= cd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      size_ff     <= size_in;
      off_ff      <= off_in;
      wdata_ff    <= wdata_in;
      cyc_ff      <= cyc_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/sprbt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "serial_port_registers_baud_timer_defines.svh"
module sprbt_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [sprbt_pkg::RspDataWidth-1:0] rsp_tdata
);

   // a held response keeps its payload
   `SPRBT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // one request in flight: no new request right after one is taken
   `SPRBT_ASSERT(a_one_in_flight, clock, reset, req_tvalid && req_tready |=> !req_tready, "request accepted while busy")

   // the transmitted byte is zero unless tx_valid is set
   `SPRBT_ASSERT(a_txbyte_zero, clock, reset, rsp_tvalid && !rsp_tdata[33] |-> rsp_tdata[41:34] == 8'h00, "tx_byte set without tx_valid")

   // reset leaves an empty response slot and a ready input
   `SPRBT_ASSERT_NORST(a_after_reset, clock, reset |=> !rsp_tvalid && req_tready, "bad state after reset")

endmodule

bind serial_port_registers_baud_timer sprbt_checker u_sprbt_checker (.*);
`default_nettype wire

/* tb/serial_regs_monitor.sv */
`timescale 1ns / 1ps
module serial_regs_monitor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_wr_data,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [sprbt_pkg::ReqDataWidth-1:0] req_tdata,
   input  wire logic [1:0]                         req_tuser,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [sprbt_pkg::RspDataWidth-1:0] rsp_tdata,
   output int                                      fail_count,
   output int                                      pending,
   output int                                      checked
);
   import sprbt_pkg::*;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_raise;
      logic        tx_valid;
      logic [7:0]  tx_byte;
   } reg_response_type;

   logic               echo_on;
   logic [15:0]        mode_q;
   logic [15:0]        ctl_q;
   logic [15:0]        baud_q;
   logic               tx_ready_q;
   logic               tx_idle_q;
   logic               irq_q;
   logic [CdWidth-1:0] countdown;

   reg_response_type resp;
   reg_response_type want;
   reg_response_type got;
   reg_response_type owed_responses[$];

   function automatic logic [CdWidth-1:0] reload_count();
      logic [CdWidth-1:0] r;
      case (mode_q[1:0])
         2'd2:    r = CdWidth'(baud_q) << 4;
         2'd3:    r = CdWidth'(baud_q) << 6;
         default: r = CdWidth'(baud_q);
      endcase
      if (r == '0) begin
         r = CdWidth'(1);
      end
      return r;
   endfunction

   function automatic void restore_defaults();
      mode_q     = '0;
      ctl_q      = '0;
      baud_q     = BaudReset;
      tx_ready_q = 1'b1;
      tx_idle_q  = 1'b1;
      irq_q      = 1'b0;
      countdown  = reload_count();
   endfunction

   function automatic logic [31:0] status_word();
      logic [31:0] s;
      s                = '0;
      s[0]             = tx_ready_q;
      s[StIdleBit]     = tx_idle_q;
      s[StIrqBit]      = irq_q;
      s[31:TimerShift] = countdown[TimerBits-1:0];
      return s;
   endfunction

   // only a clear-to-set change of the latch shows up in the response
   function automatic void raise_irq();
      if (!irq_q) begin
         irq_q          = 1'b1;
         resp.irq_raise = 1'b1;
      end
   endfunction

   function automatic void transmit(input logic [7:0] b);
      if (!ctl_q[CtlTxEn]) begin
         return;
      end
      if (echo_on) begin
         resp.tx_valid = 1'b1;
         resp.tx_byte  = b;
      end
      tx_ready_q = 1'b1;
      tx_idle_q  = 1'b1;
      if (ctl_q[CtlTxIrq]) begin
         raise_irq();
      end
   endfunction

   function automatic void write_control(input logic [15:0] v);
      if (v[CtlReset]) begin
         restore_defaults();
         return;
      end
      if (v[CtlAck]) begin
         irq_q = 1'b0;
      end
      ctl_q           = v;
      ctl_q[CtlAck]   = 1'b0;
      ctl_q[CtlReset] = 1'b0;
      if (ctl_q[CtlTxIrq] && ctl_q[CtlTxEn] && tx_idle_q) begin
         raise_irq();
      end
   endfunction

   function automatic logic [15:0] read_half(input logic [3:0] off);
      logic [31:0] s;
      logic [15:0] h;
      s = status_word();
      case (off[3:1])
         HW_DATA0, HW_DATA1: h = 16'hFFFF;
         HW_STAT_LO:         h = s[15:0];
         HW_STAT_HI:         h = s[31:16];
         HW_MODE:            h = mode_q;
         HW_CTL:             h = ctl_q;
         HW_BAUD:            h = baud_q;
         default:            h = 16'h0000;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] read_word(input logic [3:0] off);
      logic [31:0] w;
      case (off[3:2])
         WD_DATA:    w = 32'hFFFF_FFFF;
         WD_STAT:    w = status_word();
         WD_MODECTL: w = {ctl_q, mode_q};
         default:    w = {baud_q, 16'h0000};
      endcase
      return w;
   endfunction

   function automatic void write_half(input logic [3:0] off, input logic [15:0] d);
      case (off[3:1])
         HW_DATA0, HW_DATA1: transmit(d[7:0]);
         HW_MODE:            mode_q = d;
         HW_CTL:             write_control(d);
         HW_BAUD: begin
            baud_q    = d;
            countdown = reload_count();
         end
         default: ;
      endcase
   endfunction

   // narrow writes elsewhere merge into the halfword as it reads back
   function automatic void write_byte(input logic [3:0] off, input logic [7:0] d);
      logic [15:0] h;
      if (off[3:1] == HW_DATA0) begin
         transmit(d);
         return;
      end
      h = read_half(off);
      if (off[0]) begin
         h[15:8] = d;
      end else begin
         h[7:0] = d;
      end
      write_half(off, h);
   endfunction

   function automatic void write_word(input logic [3:0] off, input logic [31:0] d);
      case (off[3:2])
         WD_DATA: transmit(d[7:0]);
         WD_MODECTL: begin
            mode_q = d[15:0];
            write_control(d[31:16]);
         end
         WD_BAUD: begin
            baud_q    = d[31:16];
            countdown = reload_count();
         end
         default: ;
      endcase
   endfunction

   function automatic void advance_timer(input logic [15:0] cyc);
      int unsigned left;
      int unsigned r;
      if (CdWidth'(cyc) < countdown) begin
         countdown = countdown - CdWidth'(cyc);
      end else begin
         left      = 32'(cyc) - 32'(countdown);
         r         = 32'(reload_count());
         countdown = CdWidth'(r - (left % r));
      end
   endfunction

   function automatic reg_response_type apply_request(input logic [1:0]  op,
                                                      input logic [1:0]  size,
                                                      input logic [3:0]  off,
                                                      input logic [31:0] d,
                                                      input logic [15:0] cyc);
      logic [15:0] h;
      resp = '0;
      case (op)
         OP_READ: begin
            h = read_half(off);
            if (size == SZ_BYTE) begin
               resp.read_data = off[0] ? {24'h0, h[15:8]} : {24'h0, h[7:0]};
            end else if (size == SZ_HALF) begin
               resp.read_data = {16'h0, h};
            end else if (size == SZ_WORD) begin
               resp.read_data = read_word(off);
            end
         end
         OP_WRITE: begin
            case (size)
               SZ_BYTE: write_byte(off, d[7:0]);
               SZ_HALF: write_half(off, d[15:0]);
               SZ_WORD: write_word(off, d);
               default: ;
            endcase
         end
         OP_TICK: advance_timer(cyc);
         default: ;
      endcase
      return resp;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         echo_on    = 1'b0;
         fail_count = 0;
         checked    = 0;
         restore_defaults();
         owed_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[31:0];
            got.irq_raise = rsp_tdata[32];
            got.tx_valid  = rsp_tdata[33];
            got.tx_byte   = rsp_tdata[41:34];
            if (owed_responses.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response with no request outstanding, data %h",
                           $time, rsp_tdata);
               end
            end else begin
               want = owed_responses.pop_front();
               checked++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: response %0d differs (expected / actual)",
                              $time, checked);
                     $display("   read_data %h / %h  irq_raise %b / %b", want.read_data,
                              got.read_data, want.irq_raise, got.irq_raise);
                     $display("   tx_valid %b / %b  tx_byte %h / %h", want.tx_valid,
                              got.tx_valid, want.tx_byte, got.tx_byte);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            echo_on = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            owed_responses.push_back(apply_request(req_tuser, req_tdata[1:0],
                                                   req_tdata[5:2], req_tdata[37:6],
                                                   req_tdata[53:38]));
         end
      end
      pending <= owed_responses.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import sprbt_pkg::*;

   // request kind and access size codes the block treats as no-ops
   localparam logic [1:0] OP_NOOP = 2'd3;
   localparam logic [1:0] SZ_NONE = 2'd3;

   localparam logic [15:0] TxOn    = 16'(1 << CtlTxEn);
   localparam logic [15:0] AckOn   = 16'(1 << CtlAck);
   localparam logic [15:0] ResetOn = 16'(1 << CtlReset);
   localparam logic [15:0] TxIrqOn = 16'(1 << CtlTxIrq);

   localparam int StallLimit    = 2000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles   = 30;
   localparam int PhaseItems    = 155;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic                    csr_wr_data = 1'b0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata   = '0;
   logic [1:0]              req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_toggle    = 1'b0;
   logic hold_seen      = 1'b0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;
   int   fail_count;
   int   pending;
   int   checked;
   int   n_read         = 0;
   int   n_write        = 0;
   int   n_tick         = 0;
   int   n_other        = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   serial_port_registers_baud_timer uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   serial_regs_monitor regs_watch (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   // response side: random stalls, plus a long hold-off on each toggle request
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HoldOffCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("timeout: nothing accepted for %0d cycles, %0d responses owed",
                  StallLimit, pending);
         $display("serial_port_registers_baud_timer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // valid stays high between back-to-back requests
   task automatic send_request(input logic [1:0] op, input logic [1:0] sz,
                               input logic [3:0] off, input logic [31:0] d,
                               input logic [15:0] cyc);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, cyc, d, off, sz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         OP_READ:  n_read++;
         OP_WRITE: n_write++;
         OP_TICK:  n_tick++;
         default:  n_other++;
      endcase
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_echo(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_request();
      logic [1:0]  op;
      logic [1:0]  sz;
      logic [3:0]  off;
      logic [31:0] d;
      logic [15:0] cyc;
      int          pick;
      pick = $urandom_range(99);
      sz   = 2'($urandom_range(2));
      off  = 4'($urandom_range(15));
      d    = $urandom();
      cyc  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(400));
      // keep soft resets rare so state builds up between them
      if ($urandom_range(9) != 0) begin
         d[CtlReset]    = 1'b0;
         d[16+CtlReset] = 1'b0;
      end
      if ($urandom_range(3) != 0) begin
         d[CtlTxEn]    = 1'b1;
         d[16+CtlTxEn] = 1'b1;
      end
      // short reload periods make ticks wrap often
      if ($urandom_range(1) == 0) begin
         d[15:8]  = 8'h00;
         d[31:24] = 8'h00;
      end
      if (pick < 4) begin
         op = OP_NOOP;
      end else if (pick < 34) begin
         op = OP_READ;
      end else if (pick < 74) begin
         op = OP_WRITE;
      end else begin
         op = OP_TICK;
      end
      if ($urandom_range(24) == 0) begin
         sz = SZ_NONE;
      end
      send_request(op, sz, off, d, cyc);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_echo(1'b1);

      send_request(OP_READ, SZ_WORD, {WD_STAT, 2'b00}, 32'h0, 16'h0);
      send_request(OP_READ, SZ_BYTE, {HW_STAT_HI, 1'b1}, 32'h0, 16'h0);
      send_request(OP_READ, SZ_HALF, {HW_BAUD, 1'b0}, 32'h0, 16'h0);
      // arming the transmit interrupt while idle raises it
      send_request(OP_WRITE, SZ_HALF, {HW_CTL, 1'b0}, 32'(TxOn | TxIrqOn), 16'h0);
      send_request(OP_WRITE, SZ_BYTE, {HW_DATA0, 1'b0}, 32'hFFFF_FFA5, 16'h0);
      send_request(OP_WRITE, SZ_HALF, {HW_CTL, 1'b0}, 32'(TxOn | AckOn), 16'h0);
      // byte write to the upper data half merges with the idle-line value
      send_request(OP_WRITE, SZ_BYTE, {HW_DATA1, 1'b1}, 32'h0000_005A, 16'h0);
      send_request(OP_WRITE, SZ_WORD, {WD_MODECTL, 2'b00},
                   {TxOn | TxIrqOn | AckOn, 16'h0003}, 16'h0);
      send_request(OP_WRITE, SZ_WORD, {WD_DATA, 2'b00}, 32'h0000_0042, 16'h0);
      send_request(OP_READ, SZ_WORD, {WD_MODECTL, 2'b00}, 32'h0, 16'h0);
      // zero baud reloads as one
      send_request(OP_WRITE, SZ_HALF, {HW_BAUD, 1'b0}, 32'h0, 16'h0);
      send_request(OP_TICK, SZ_BYTE, 4'h0, 32'h0, 16'hFFFF);
      send_request(OP_WRITE, SZ_WORD, {WD_BAUD, 2'b00}, 32'hFFFF_0000, 16'h0);
      send_request(OP_TICK, SZ_HALF, 4'h0, 32'h0, 16'h0000);
      send_request(OP_TICK, SZ_WORD, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(OP_READ, SZ_HALF, {HW_STAT_HI, 1'b0}, 32'h0, 16'h0);
      send_request(OP_WRITE, SZ_HALF, {HW_MODE, 1'b0}, 32'h0000_0002, 16'h0);
      send_request(OP_WRITE, SZ_BYTE, {HW_BAUD, 1'b1}, 32'h0000_0001, 16'h0);
      send_request(OP_TICK, SZ_BYTE, 4'h0, 32'h0, 16'h1234);
      send_request(OP_WRITE, SZ_BYTE, {HW_STAT_LO, 1'b1}, 32'h0000_00FF, 16'h0);
      send_request(OP_WRITE, SZ_HALF, {HW_UNUSED, 1'b0}, 32'h0000_FFFF, 16'h0);
      send_request(OP_READ, SZ_HALF, {HW_UNUSED, 1'b0}, 32'h0, 16'h0);
      send_request(OP_READ, SZ_NONE, 4'hF, 32'h0, 16'h0);
      send_request(OP_WRITE, SZ_NONE, {HW_CTL, 1'b0}, 32'(ResetOn), 16'h0);
      send_request(OP_NOOP, SZ_WORD, {WD_MODECTL, 2'b00}, 32'hFFFF_FFFF, 16'hFFFF);
      // reset strobe drops the rest of the control value
      send_request(OP_WRITE, SZ_HALF, {HW_CTL, 1'b0}, 32'h0000_FFFF, 16'h0);
      send_request(OP_WRITE, SZ_HALF, {HW_CTL, 1'b0}, 32'(TxIrqOn), 16'h0);
      send_request(OP_WRITE, SZ_WORD, {WD_DATA, 2'b00}, 32'h0000_0077, 16'h0);
      send_request(OP_READ, SZ_WORD, {WD_STAT, 2'b00}, 32'h0, 16'h0);

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         set_echo(phase[0]);
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct  = 48;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct <= 48;
            end
            default: begin
               send_idle_pct  = 7;
               recv_stall_pct <= 7;
            end
         endcase
         for (int i = 0; i < PhaseItems; i++) begin
            if (phase == 0 && i == 60) begin
               hold_toggle <= ~hold_toggle;
            end
            if (phase == 2 && i == 80) begin
               wait_idle();
            end
            random_request();
         end
      end

      wait_idle();
      $display("covered %0d requests: %0d reads, %0d writes, %0d ticks, %0d no-ops",
               n_read + n_write + n_tick + n_other, n_read, n_write, n_tick, n_other);
      $display("%0d responses checked, echo off and on, four idle mixes, %0d-cycle hold-off",
               checked, HoldOffCycles);
      if (fail_count == 0) begin
         $display("serial_port_registers_baud_timer regression: pass");
      end else begin
         $display("serial_port_registers_baud_timer regression: fail");
      end
      $finish;
   end

endmodule
